### sv/avud_pkg.sv
// Package for the averaged undervoltage detector.
// Shared widths, reset values and register codes; no dependencies.
`default_nettype none

package avud_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int RING_DEPTH      = 4;
    localparam int PTR_BITS        = $clog2(RING_DEPTH);

    localparam int THR_BITS        = 12;
    localparam int LIMIT_BITS      = 4;
    localparam int COUNT_BITS      = 5;

    localparam logic [THR_BITS-1:0]   THR_RESET   = '0;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(3);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [0:0] {
        REG_LOW_THRESHOLD  = 1'b0,
        REG_DEBOUNCE_LIMIT = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

### sv/avud_ring.sv
// Four-entry sample ring with write pointer and first-tick fill.
// Produces the floor mean of the ring after the current sample; uses avud_pkg.
`default_nettype none

module avud_ring
    import avud_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic      [SAMPLE_BITS-1:0] average
);

    localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;

    logic [SAMPLE_BITS-1:0] ring_reg  [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] ring_next [RING_DEPTH];
    logic [PTR_BITS-1:0]    wp_reg;
    logic [PTR_BITS-1:0]    wp_next;
    logic                   first_reg;
    logic [SUM_BITS-1:0]    sum;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < RING_DEPTH; k++)
        begin
            if (first_reg || (wp_reg == PTR_BITS'(k)))
                ring_next[k] = sample;
            else
                ring_next[k] = ring_reg[k];
            sum = sum + SUM_BITS'(ring_next[k]);
        end
        wp_next = first_reg ? wp_reg : wp_reg + 1'b1;
        average = sum[SUM_BITS-1:PTR_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RING_DEPTH; k++)
                ring_reg[k] <= ring_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            first_reg <= 1'b1;
        end
        else if (en)
        begin
            wp_reg    <= wp_next;
            first_reg <= 1'b0;
        end
    end

    a_first_ptr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg |-> (wp_reg == '0))
        else $error("write pointer moved before first sample");

endmodule

`default_nettype wire

### sv/avud_debounce.sv
// Consecutive-low counter and low-voltage flag.
// Compares the average against the threshold; uses avud_pkg.
`default_nettype none

module avud_debounce
    import avud_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic [SAMPLE_BITS-1:0] average,
    input  wire logic [THR_BITS-1:0]    low_threshold,
    input  wire logic [LIMIT_BITS-1:0]  debounce_limit,
    output logic                        flag_next
);

    localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  flag_reg;
    logic                  is_low;

    always_comb
    begin
        is_low = CMP_BITS'(average) < CMP_BITS'(low_threshold);
        if (is_low)
        begin
            flag_next  = flag_reg || (count_reg > COUNT_BITS'(debounce_limit));
            count_next = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        end
        else
        begin
            flag_next  = 1'b0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (en)
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    a_flag_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |-> (count_reg != '0))
        else $error("flag set with zero low count");

endmodule

`default_nettype wire

### sv/averaged_undervoltage_detector_top.sv
// Averaged undervoltage detector, top level: input register, ring average,
// debounce and result register, plus the APB register file.
// Each input transfer passes the input register, then the result register. Throughput:
// one transfer per cycle while out_stall does not hold the result register; the
// ring/debounce update is combinational between input and result registers.
// Reset: async active-low; clears pipeline valids, ring pointer, counter and
// flag, and loads threshold 0 and debounce limit 3. Depends on avud_pkg.
`default_nettype none

module averaged_undervoltage_detector_top
    import avud_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [SAMPLE_BITS-1:0]   sample,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic      [SAMPLE_BITS-1:0]   average,
    output logic                          low_flag,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    logic [THR_BITS-1:0]    thr_reg;
    logic [LIMIT_BITS-1:0]  limit_reg;
    cfg_reg_t               reg_sel;
    logic                   cfg_wr;

    logic                   in_vld_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   out_vld_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic                   flag_out_reg;

    logic                   advance;
    logic                   work_en;
    logic [SAMPLE_BITS-1:0] avg_next;
    logic                   flag_next;

    // register file
    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            REG_LOW_THRESHOLD:  prdata = APB_DATA_BITS'(thr_reg);
            REG_DEBOUNCE_LIMIT: prdata = APB_DATA_BITS'(limit_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_LOW_THRESHOLD:  thr_reg   <= pwdata[THR_BITS-1:0];
                REG_DEBOUNCE_LIMIT: limit_reg <= pwdata[LIMIT_BITS-1:0];
                default:            thr_reg   <= thr_reg;
            endcase
        end
    end

    // pipeline control
    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;
    assign work_en  = in_vld_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_sample_reg <= sample;
        if (work_en)
        begin
            avg_reg      <= avg_next;
            flag_out_reg <= flag_next;
        end
    end

    avud_ring #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (work_en),
        .sample  (in_sample_reg),
        .average (avg_next)
    );

    avud_debounce #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (work_en),
        .average        (avg_next),
        .low_threshold  (thr_reg),
        .debounce_limit (limit_reg),
        .flag_next      (flag_next)
    );

    assign out_valid = out_vld_reg;
    assign average   = avg_reg;
    assign low_flag  = flag_out_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled with free pipeline");

    a_result_taken_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |=> (out_vld_reg && $stable(avg_reg)
            && $stable(flag_out_reg)))
        else $error("pending result overwritten");

    a_flag_only_when_low: assert property (@(posedge clk) disable iff (!rst_n)
        work_en && flag_next |-> (avg_next < SAMPLE_BITS'(thr_reg)
            || SAMPLE_BITS < THR_BITS))
        else $error("flag raised on average at or above threshold");

endmodule

`default_nettype wire

### bench/tb_averaged_undervoltage_detector_top.sv
// Self-checking bench for averaged_undervoltage_detector_top: a local model of the
// four-sample ring average and debounced low flag checks every result transfer.
// Depends on avud_pkg and the top-level RTL only.
`default_nettype none

module tb_averaged_undervoltage_detector_top;
    import avud_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [SB-1:0] average;
        logic          low_flag;
    } uv_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [SB-1:0]            sample = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [SB-1:0]            average;
    logic                     low_flag;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    averaged_undervoltage_detector_top #(.SAMPLE_BITS(SB)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall), .average(average), .low_flag(low_flag),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // model state
    logic [SB-1:0]         ring_q [RING_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_q = '0;
    logic                  first_q = 1'b1;
    logic [COUNT_BITS-1:0] low_cnt_q = '0;
    logic                  flag_q = 1'b0;
    logic [THR_BITS-1:0]   thr_q = THR_RESET;
    logic [LIMIT_BITS-1:0] limit_q = LIMIT_RESET;

    uv_result_t pending_results [$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_requests = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         errors = 0;
    int         samples_sent = 0;
    int         results_seen = 0;
    int         flags_seen = 0;
    int         cfg_writes = 0;
    int         cycles = 0;

    initial
    begin
        for (int k = 0; k < RING_DEPTH; k++)
            ring_q[k] = '0;
    end

    function automatic uv_result_t predict_tick(logic [SB-1:0] s);
        uv_result_t   r;
        logic [SB+1:0] total;
        if (first_q)
        begin
            first_q = 1'b0;
            for (int k = 0; k < RING_DEPTH; k++)
                ring_q[k] = s;
        end
        else
        begin
            ring_q[wr_ptr_q] = s;
            wr_ptr_q = wr_ptr_q + 1'b1;
        end
        total = '0;
        for (int k = 0; k < RING_DEPTH; k++)
            total = total + ring_q[k];
        r.average = total[SB+1:2];
        if (r.average < thr_q)
        begin
            if (low_cnt_q > limit_q)
                flag_q = 1'b1;
            if (low_cnt_q != COUNT_MAX)
                low_cnt_q = low_cnt_q + 1'b1;
        end
        else
        begin
            low_cnt_q = '0;
            flag_q = 1'b0;
        end
        r.low_flag = flag_q;
        return r;
    endfunction

    // result side: checking
    always @(posedge clk)
    begin
        uv_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (low_flag)
                flags_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: average=%0d low_flag=%0b",
                             average, low_flag);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.average !== average || exp_r.low_flag !== low_flag)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: average exp %0d got %0d, low_flag exp %0b got %0b",
                                 exp_r.average, average, exp_r.low_flag, low_flag);
                end
            end
        end
    end

    // result side: stall generation and long hold-off
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_sample(logic [SB-1:0] s);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_tick(s));
        samples_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t r, logic [APB_DATA_BITS-1:0] data);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({r, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_LOW_THRESHOLD)
            thr_q = data[THR_BITS-1:0];
        else
            limit_q = data[LIMIT_BITS-1:0];
        cfg_writes++;
        @(posedge clk);
    endtask

    // upper bits are random junk and must be ignored
    task automatic set_config(int thr, int lim);
        cfg_write(REG_LOW_THRESHOLD, ($urandom() & ~32'hFFF) | (thr & 32'hFFF));
        cfg_write(REG_DEBOUNCE_LIMIT, ($urandom() & ~32'hF) | (lim & 32'hF));
    endtask

    task automatic test_first_tick();
        send_sample(12'hABC);
        send_sample(12'h000);
    endtask

    task automatic test_extremes();
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'h000);
    endtask

    task automatic test_debounce();
        set_config(2048, 0);
        repeat (5) send_sample(12'h000);
        send_sample(12'hFFF);
        repeat (4) send_sample(12'h000);
        set_config(2048, 3);
        repeat (7) send_sample(12'h000);
        repeat (2) send_sample(12'hFFF);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(3000, 2);
        hold_requests++;
        repeat (30) send_sample(SB'($urandom_range(0, 4095)));
        wait_drained();
        repeat (10) send_sample(SB'($urandom_range(0, 4095)));
    endtask

    // mostly low runs followed by short recoveries, some plain noise
    task automatic random_burst(int n);
        int left;
        int run;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 70 && thr_q != 0)
            begin
                run = $urandom_range(1, 40);
                for (int k = 0; k < run && left > 0; k++, left--)
                    send_sample(SB'($urandom_range(0, thr_q - 1)));
                run = $urandom_range(1, 4);
                for (int k = 0; k < run && left > 0; k++, left--)
                    send_sample(SB'($urandom_range(thr_q, 4095)));
            end
            else
            begin
                run = $urandom_range(1, 8);
                for (int k = 0; k < run && left > 0; k++, left--)
                    send_sample(SB'($urandom_range(0, 4095)));
            end
        end
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int thr0, int lim0);
        set_config(thr0, lim0);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        random_burst(50);
        for (int seg = 0; seg < 4; seg++)
        begin
            set_config($urandom_range(0, 4095), $urandom_range(0, 15));
            random_burst(50);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_tick();
        test_extremes();
        test_debounce();
        test_backpressure();
        test_random_phase(0, 0, 4095, 15);
        test_random_phase(82, 0, 0, 0);
        test_random_phase(0, 82, 4095, 0);
        test_random_phase(26, 26, 2048, 15);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d sample transfers, %0d results (%0d flagged), %0d register writes",
                 samples_sent, results_seen, flags_seen, cfg_writes);
        $display("pacing: free-running, sparse input, heavy output stall, mixed, long hold-off");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
sv/avud_pkg.sv
sv/avud_ring.sv
sv/avud_debounce.sv
sv/averaged_undervoltage_detector_top.sv
bench/tb_averaged_undervoltage_detector_top.sv
